### rtl/srpt_pkg.sv
// ----------------------------------------------------------------------------
// srpt_pkg : stepper reel position tracker package
// Request and result types, register indexes, pass lengths, sequencer states and the phase move table.
// ----------------------------------------------------------------------------
package srpt_pkg;

    localparam int NUM_REELS = 8;
    localparam int REEL_W    = (NUM_REELS > 1) ? $clog2(NUM_REELS) : 1;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_STEPS_PER_REV   = 3'd0;
    localparam logic [2:0] CFG_STEPS_PER_STOP  = 3'd1;
    localparam logic [2:0] CFG_POSITION_ADJUST = 3'd2;
    localparam logic [2:0] CFG_OPTO_START      = 3'd3;
    localparam logic [2:0] CFG_OPTO_END        = 3'd4;
    localparam logic [2:0] CFG_INVERT_MASK     = 3'd5;

    // Dividend lengths (bits) for each pass of the remainder unit
    localparam logic [3:0] LEN_POS  = 4'd11;
    localparam logic [3:0] LEN_STOP = 4'd8;
    localparam logic [3:0] LEN_DISP = 4'd9;

    typedef struct packed {
        logic [2:0] reel_index;
        logic [3:0] drive_pattern;
    } t_in_req;

    typedef struct packed {
        logic [7:0] position;
        logic [7:0] display_position;
        logic [7:0] opto_bits;
        logic       stop_reached;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_POS,
        ST_MOD_STOP,
        ST_MOD_DISP,
        ST_DONE
    } t_state;

    // Move in half steps, indexed by (position mod 8) and the new drive pattern
    localparam logic signed [2:0] PHASE_MOVE [0:7][0:15] = '{
        '{3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd2, 3'sd1, 3'sd3, 3'sd0,
          -3'sd2, -3'sd1, -3'sd3, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, -3'sd1, 3'sd3, 3'sd0, 3'sd1, 3'sd0, 3'sd2, 3'sd0,
          -3'sd3, -3'sd2, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, -3'sd2, 3'sd2, 3'sd0, 3'sd0, -3'sd1, 3'sd1, 3'sd0,
          3'sd0, -3'sd3, 3'sd3, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, -3'sd3, 3'sd1, 3'sd0, -3'sd1, -3'sd2, 3'sd0, 3'sd0,
          3'sd3, 3'sd0, 3'sd2, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, 3'sd0, 3'sd0, 3'sd0, -3'sd2, -3'sd3, -3'sd1, 3'sd0,
          3'sd2, 3'sd3, 3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, 3'sd3, -3'sd1, 3'sd0, -3'sd3, 3'sd0, -3'sd2, 3'sd0,
          3'sd1, 3'sd2, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, 3'sd2, -3'sd2, 3'sd0, 3'sd0, 3'sd3, -3'sd3, 3'sd0,
          3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd0, 3'sd1, -3'sd3, 3'sd0, 3'sd3, 3'sd2, 3'sd0, 3'sd0,
          -3'sd1, 3'sd0, -3'sd2, 3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd0}
    };

endpackage

### rtl/stepper_reel_position_tracker_core.sv
// ----------------------------------------------------------------------------
// stepper_reel_position_tracker_core
// Tracks reel positions from stepper drive patterns using one shared
// restoring remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
// Timing: an accepted request runs the position, stop and display
//   remainder passes in turn through the one shift/subtract unit, then
//   waits in the commit state until the output register is free.
// Throughput: no new request is taken while one is in progress; a
//   new request is taken in the cycle after the result is handed to the
//   output register.
// Reset (i_rst_n low, synchronous): configuration registers to their defaults, all reel
//   positions, last patterns and opto bits to zero, output empty.
module stepper_reel_position_tracker_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  srpt_pkg::t_in_req    i_in_req,
    // result out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output srpt_pkg::t_out_req   o_out_req,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_steps_per_rev;
    logic [7:0] r_steps_per_stop;
    logic [7:0] r_position_adjust;
    logic [7:0] r_opto_start;
    logic [7:0] r_opto_end;
    logic [7:0] r_invert_mask;

    // Writes beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_rev   <= 8'd96;
            r_steps_per_stop  <= 8'd1;
            r_position_adjust <= 8'd0;
            r_opto_start      <= 8'd0;
            r_opto_end        <= 8'd0;
            r_invert_mask     <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                srpt_pkg::CFG_STEPS_PER_REV:   r_steps_per_rev   <= i_cfg_data;
                srpt_pkg::CFG_STEPS_PER_STOP:  r_steps_per_stop  <= i_cfg_data;
                srpt_pkg::CFG_POSITION_ADJUST: r_position_adjust <= i_cfg_data;
                srpt_pkg::CFG_OPTO_START:      r_opto_start      <= i_cfg_data;
                srpt_pkg::CFG_OPTO_END:        r_opto_end        <= i_cfg_data;
                srpt_pkg::CFG_INVERT_MASK:     r_invert_mask     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // A zero count means 256 for both the revolution and the stop spacing
    logic [8:0] s_eff;
    logic [8:0] ss_eff;
    assign s_eff  = (r_steps_per_rev  == 8'd0) ? 9'd256 : {1'b0, r_steps_per_rev};
    assign ss_eff = (r_steps_per_stop == 8'd0) ? 9'd256 : {1'b0, r_steps_per_stop};

    // ------------------------------------------------------------------
    // Reel state
    // ------------------------------------------------------------------
    logic [7:0] r_pos  [srpt_pkg::NUM_REELS];
    logic [3:0] r_last [srpt_pkg::NUM_REELS];
    logic [7:0] r_opto;

    // ------------------------------------------------------------------
    // Sequencer and remainder unit registers
    // ------------------------------------------------------------------
    srpt_pkg::t_state r_state, n_state;
    logic [3:0]  r_cnt,  n_cnt;     // remainder steps left in this pass
    logic [10:0] r_dvd,  n_dvd;     // dividend, MSB first
    logic [8:0]  r_rem,  n_rem;     // partial remainder, always below r_div
    logic [8:0]  r_div,  n_div;
    logic [2:0]  r_idx,  n_idx;
    logic [3:0]  r_pat,  n_pat;
    logic        r_ok,   n_ok;      // reel index is within NUM_REELS
    logic        r_chg,  n_chg;     // pattern differs: the reel state is updated
    logic [7:0]  r_old,  n_old;     // stored position before the move
    logic [7:0]  r_pmod, n_pmod;    // new position, or stored position mod rev
    logic        r_stop, n_stop;
    logic [7:0]  r_disp, n_disp;

    logic               r_out_valid, n_out_valid;
    srpt_pkg::t_out_req r_out_req,   n_out_req;

    // Shared restoring remainder step: shift in one dividend bit, subtract if fits
    logic [9:0] trial;
    logic       fits;
    logic [8:0] diff;
    logic [8:0] rem_next;
    assign trial    = {r_rem, r_dvd[10]};
    assign fits     = trial >= {1'b0, r_div};
    assign diff     = 9'(trial - {1'b0, r_div});
    assign rem_next = fits ? diff : trial[8:0];

    // Request decode from the addressed reel
    logic                    in_ok;
    logic [srpt_pkg::REEL_W-1:0] in_sel;
    logic [7:0]              in_old;
    logic [3:0]              in_last;
    logic                    in_chg;
    logic signed [2:0]       in_mv;
    logic [10:0]             in_sum;

    assign in_ok   = {2'b00, i_in_req.reel_index} < 5'(srpt_pkg::NUM_REELS);
    assign in_sel  = i_in_req.reel_index[srpt_pkg::REEL_W-1:0];
    assign in_old  = in_ok ? r_pos[in_sel] : 8'd0;
    assign in_last = in_ok ? r_last[in_sel] : 4'd0;
    assign in_chg  = in_ok && (i_in_req.drive_pattern != in_last);
    assign in_mv   = srpt_pkg::PHASE_MOVE[in_old[2:0]][i_in_req.drive_pattern];
    // old + 3*rev + move stays non-negative before the wrap
    assign in_sum  = {3'b000, in_old} + {1'b0, s_eff, 1'b0} + {2'b00, s_eff}
                   + {{8{in_mv[2]}}, in_mv};

    // Display dividend: rev + adjust - (position mod rev), never negative
    logic [8:0] disp_dvd;
    assign disp_dvd = s_eff + {1'b0, r_position_adjust} - {1'b0, r_pmod};

    // Opto sense of the moved reel
    logic in_window;
    logic opto_bit;
    assign in_window = (r_pmod > r_opto_start) && (r_pmod < r_opto_end);
    assign opto_bit  = in_window ^ r_invert_mask[r_idx];

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    logic [7:0] new_opto;
    always_comb begin
        new_opto = r_opto;
        if (r_chg) begin
            new_opto[r_idx] = opto_bit;
        end
    end

    logic commit;
    assign commit = (r_state == srpt_pkg::ST_DONE) && out_free;

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_div       = r_div;
        n_idx       = r_idx;
        n_pat       = r_pat;
        n_ok        = r_ok;
        n_chg       = r_chg;
        n_old       = r_old;
        n_pmod      = r_pmod;
        n_stop      = r_stop;
        n_disp      = r_disp;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_req   = r_out_req;

        unique case (r_state)
            srpt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = i_in_req.reel_index;
                    n_pat   = i_in_req.drive_pattern;
                    n_ok    = in_ok;
                    n_chg   = in_chg;
                    n_old   = in_old;
                    n_dvd   = in_chg ? in_sum : {3'b000, in_old};
                    n_cnt   = srpt_pkg::LEN_POS;
                    n_rem   = 9'd0;
                    n_div   = s_eff;
                    n_state = srpt_pkg::ST_MOD_POS;
                end
            end
            srpt_pkg::ST_MOD_POS: begin
                n_rem = rem_next;
                n_dvd = {r_dvd[9:0], 1'b0};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_pmod  = rem_next[7:0];
                    n_dvd   = {rem_next[7:0], 3'b000};
                    n_cnt   = srpt_pkg::LEN_STOP;
                    n_rem   = 9'd0;
                    n_div   = ss_eff;
                    n_state = srpt_pkg::ST_MOD_STOP;
                end
            end
            srpt_pkg::ST_MOD_STOP: begin
                n_rem = rem_next;
                n_dvd = {r_dvd[9:0], 1'b0};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_stop  = r_chg && (r_old != r_pmod) && (rem_next == 9'd0);
                    n_dvd   = {disp_dvd, 2'b00};
                    n_cnt   = srpt_pkg::LEN_DISP;
                    n_rem   = 9'd0;
                    n_div   = s_eff;
                    n_state = srpt_pkg::ST_MOD_DISP;
                end
            end
            srpt_pkg::ST_MOD_DISP: begin
                n_rem = rem_next;
                n_dvd = {r_dvd[9:0], 1'b0};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_disp  = rem_next[7:0];
                    n_state = srpt_pkg::ST_DONE;
                end
            end
            srpt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid                  = 1'b1;
                    n_out_req.position           = !r_ok ? 8'd0 : (r_chg ? r_pmod : r_old);
                    n_out_req.display_position   = r_ok ? r_disp : 8'd0;
                    n_out_req.opto_bits          = new_opto;
                    n_out_req.stop_reached       = r_stop;
                    n_state                      = srpt_pkg::ST_IDLE;
                end
            end
            default: n_state = srpt_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_idx     <= n_idx;
        r_pat     <= n_pat;
        r_ok      <= n_ok;
        r_chg     <= n_chg;
        r_old     <= n_old;
        r_pmod    <= n_pmod;
        r_stop    <= n_stop;
        r_disp    <= n_disp;
        r_out_req <= n_out_req;
    end

    // Reel state commits as the result goes to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < srpt_pkg::NUM_REELS; i++) begin
                r_pos[i]  <= 8'd0;
                r_last[i] <= 4'd0;
            end
            r_opto <= 8'd0;
        end else if (commit && r_chg) begin
            r_pos[r_idx[srpt_pkg::REEL_W-1:0]]  <= r_pmod;
            r_last[r_idx[srpt_pkg::REEL_W-1:0]] <= r_pat;
            r_opto                              <= new_opto;
        end
    end

    assign o_in_stall  = (r_state != srpt_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpt_pkg::ST_MOD_POS || r_state == srpt_pkg::ST_MOD_STOP ||
         r_state == srpt_pkg::ST_MOD_DISP) |-> (r_rem < r_div))
        else $error("remainder unit: partial remainder not below divisor");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpt_pkg::ST_MOD_POS || r_state == srpt_pkg::ST_MOD_STOP ||
         r_state == srpt_pkg::ST_MOD_DISP) |-> (r_cnt != 4'd0))
        else $error("sequencer: step counter ran out inside a pass");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == srpt_pkg::ST_MOD_POS))
        else $error("sequencer: accepted request did not start the position pass");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == srpt_pkg::ST_DONE))
        else $error("output loaded outside the commit state");

    a_pos_in_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpt_pkg::ST_DONE) |-> ({1'b0, r_pmod} < s_eff))
        else $error("wrapped position not below steps per revolution");

endmodule

### dv/reel_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reel_tracker_checker : result checker for the stepper reel position tracker
// Watches the request, result and register channels. It keeps its own copy of
// the reel positions and registers, works out each result when a request is
// taken, and compares the results in order.
// ----------------------------------------------------------------------------
module reel_tracker_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  srpt_pkg::t_in_req    i_in_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  srpt_pkg::t_out_req   i_out_req,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [7:0] steps_per_rev;
    logic [7:0] steps_per_stop;
    logic [7:0] position_adjust;
    logic [7:0] opto_start;
    logic [7:0] opto_end;
    logic [7:0] invert_mask;

    logic [7:0] reel_pos   [0:srpt_pkg::NUM_REELS-1];
    logic [3:0] last_drive [0:srpt_pkg::NUM_REELS-1];
    logic [7:0] opto_bits;

    srpt_pkg::t_out_req   awaited_reports [$];
    srpt_pkg::t_out_req   due;

    // Half-step phase that a coil pattern pulls the rotor towards; -1 if none
    function automatic int coil_phase(logic [3:0] pat);
        case (pat)
            4'd1:    return 0;
            4'd5:    return 1;
            4'd4:    return 2;
            4'd6:    return 3;
            4'd2:    return 4;
            4'd10:   return 5;
            4'd8:    return 6;
            4'd9:    return 7;
            default: return -1;
        endcase
    endfunction

    // Applies one drive request to the mirrored reel state, returns its result
    function automatic srpt_pkg::t_out_req track_drive(srpt_pkg::t_in_req req);
        srpt_pkg::t_out_req rpt;
        int       reel;
        int       rev;
        int       stop_len;
        int       old_pos;
        int       new_pos;
        int       ph;
        int       ph_gap;
        int       move;
        logic     in_window;
        rpt  = '0;
        reel = req.reel_index;
        if (reel >= srpt_pkg::NUM_REELS) begin
            rpt.opto_bits = opto_bits;
            return rpt;
        end
        // a zero register stands for 256
        rev = (steps_per_rev == 8'd0) ? 256 : int'(steps_per_rev);
        if (req.drive_pattern != last_drive[reel]) begin
            stop_len = (steps_per_stop == 8'd0) ? 256 : int'(steps_per_stop);
            old_pos  = int'(reel_pos[reel]);
            ph       = coil_phase(req.drive_pattern);
            // shortest way round to the target phase; none when it is opposite
            ph_gap   = (ph < 0) ? 0 : ((ph - old_pos) & 7);
            if (ph_gap == 0 || ph_gap == 4)
                move = 0;
            else if (ph_gap < 4)
                move = ph_gap;
            else
                move = ph_gap - 8;
            new_pos   = (old_pos + 3 * rev + move) % rev;
            in_window = (new_pos > int'(opto_start)) && (new_pos < int'(opto_end));
            reel_pos[reel]    = 8'(new_pos);
            last_drive[reel]  = req.drive_pattern;
            rpt.stop_reached  = (old_pos != new_pos) && (new_pos % stop_len == 0);
            opto_bits[reel]   = in_window ^ invert_mask[reel];
        end
        rpt.position         = reel_pos[reel];
        rpt.display_position = 8'((rev + int'(position_adjust)
                                    - (int'(reel_pos[reel]) % rev)) % rev);
        rpt.opto_bits        = opto_bits;
        return rpt;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            steps_per_rev   = 8'd96;
            steps_per_stop  = 8'd1;
            position_adjust = 8'd0;
            opto_start      = 8'd0;
            opto_end        = 8'd0;
            invert_mask     = 8'd0;
            for (int r = 0; r < srpt_pkg::NUM_REELS; r++) begin
                reel_pos[r]   = 8'd0;
                last_drive[r] = 4'd0;
            end
            opto_bits = 8'd0;
            awaited_reports.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_reports.size() == 0) begin
                    $error("result with no request outstanding: %h", i_out_req);
                    o_fail_count++;
                end else begin
                    due = awaited_reports.pop_front();
                    if (i_out_req !== due) begin
                        if (i_out_req.position !== due.position)
                            $error("position: expected %0d, got %0d",
                                   due.position, i_out_req.position);
                        if (i_out_req.display_position !== due.display_position)
                            $error("display_position: expected %0d, got %0d",
                                   due.display_position, i_out_req.display_position);
                        if (i_out_req.opto_bits !== due.opto_bits)
                            $error("opto_bits: expected %h, got %h",
                                   due.opto_bits, i_out_req.opto_bits);
                        if (i_out_req.stop_reached !== due.stop_reached)
                            $error("stop_reached: expected %0d, got %0d",
                                   due.stop_reached, i_out_req.stop_reached);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    srpt_pkg::CFG_STEPS_PER_REV:   steps_per_rev   = i_cfg_data;
                    srpt_pkg::CFG_STEPS_PER_STOP:  steps_per_stop  = i_cfg_data;
                    srpt_pkg::CFG_POSITION_ADJUST: position_adjust = i_cfg_data;
                    srpt_pkg::CFG_OPTO_START:      opto_start      = i_cfg_data;
                    srpt_pkg::CFG_OPTO_END:        opto_end        = i_cfg_data;
                    srpt_pkg::CFG_INVERT_MASK:     invert_mask     = i_cfg_data;
                    default: ;  // spare index, no register behind it
                endcase
            end
            if (i_in_valid && !i_in_stall)
                awaited_reports.push_back(track_drive(i_in_req));
        end
        o_pending = awaited_reports.size();
    end

endmodule

### dv/stepper_reel_position_tracker_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_reel_position_tracker_core_test : top of the reel tracker bench
// Drives drive-pattern requests and register writes into the tracker, with
// random gaps and output stalls; a checker beside the block predicts and
// compares every result. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module stepper_reel_position_tracker_core_test;

    // Unmapped register index; writes to it must leave every setting alone
    localparam logic [2:0]  CFG_SPARE       = 3'd7;
    localparam int          SETTING_PHASES  = 12;
    localparam int          ITEMS_PER_PHASE = 100;
    // Well past the request-to-result latency
    localparam int          SETTLE_CYCLES   = 40;
    // Coil patterns of the eight half-step phases, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_SEQ   = {4'd9, 4'd8, 4'd10, 4'd2,
                                               4'd6, 4'd4, 4'd5, 4'd1};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    srpt_pkg::t_in_req    in_req;
    logic       out_valid;
    logic       out_stall;
    srpt_pkg::t_out_req   out_req;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int         fail_count;
    int         pending;
    // per-phase switches for stretches with no idling on either side
    logic       quiet_in;
    logic       quiet_out;
    // last pattern sent to each reel, so unchanged patterns can be repeated
    logic [3:0] last_sent [0:srpt_pkg::NUM_REELS-1];

    always #5 clk = ~clk;

    stepper_reel_position_tracker_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    reel_tracker_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // One request: optional gap with valid low, then hold it until taken.
    // Entered and left on a falling edge; valid stays high on exit so that
    // back-to-back requests need no gap with valid low.
    task automatic send_drive(input logic [2:0] reel, input logic [3:0] pat);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= srpt_pkg::t_in_req'({reel, pat});
        last_sent[reel] = pat;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding result to be taken
    task automatic drain_results;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [7:0] rev, input logic [7:0] stop_len,
                                 input logic [7:0] adjust, input logic [7:0] win_lo,
                                 input logic [7:0] win_hi, input logic [7:0] inv);
        write_reg(srpt_pkg::CFG_STEPS_PER_REV, rev);
        write_reg(srpt_pkg::CFG_STEPS_PER_STOP, stop_len);
        write_reg(srpt_pkg::CFG_POSITION_ADJUST, adjust);
        write_reg(srpt_pkg::CFG_OPTO_START, win_lo);
        write_reg(srpt_pkg::CFG_OPTO_END, win_hi);
        write_reg(srpt_pkg::CFG_INVERT_MASK, inv);
        cfg_valid <= 1'b0;
    endtask

    // Result side: a random stall before each result, then take it
    initial begin : result_sink
        int hold;
        out_stall = 1'b0;
        while (rst_n !== 1'b1) @(negedge clk);
        forever begin
            hold = quiet_out ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int         pick;
        logic [2:0] reel;
        logic [3:0] pat;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        for (int r = 0; r < srpt_pkg::NUM_REELS; r++)
            last_sent[r] = 4'd0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests at the reset settings (96 steps, window shut)
        send_drive(3'd0, 4'd0);     // same as the reset pattern: nothing moves
        send_drive(3'd0, 4'd4);     // +2
        send_drive(3'd0, 4'd4);     // unchanged pattern
        send_drive(3'd0, 4'd10);    // +3
        send_drive(3'd0, 4'd1);     // +3, onto 8
        send_drive(3'd1, 4'd10);    // -3 from zero, wraps to the top
        send_drive(3'd1, 4'd9);     // +2
        send_drive(3'd1, 4'd8);     // -1
        send_drive(3'd2, 4'd6);     // +3
        send_drive(3'd2, 4'd15);    // not a drive pattern: stored as the last pattern, no move
        send_drive(3'd2, 4'd3);
        send_drive(3'd3, 4'd2);     // opposite phase: no move, no stop pulse
        send_drive(3'd7, 4'd5);     // +1
        send_drive(3'd7, 4'd2);     // +3
        send_drive(3'd7, 4'd15);
        send_drive(3'd4, 4'd12);
        send_drive(3'd5, 4'd13);
        send_drive(3'd6, 4'd14);
        send_drive(3'd6, 4'd11);
        send_drive(3'd6, 4'd7);

        for (int phase = 0; phase < SETTING_PHASES; phase++) begin
            drain_results;
            case (phase)
                0: begin
                    // spare index first, then zero revolution and zero stop (both 256)
                    write_reg(CFG_SPARE, 8'hFF);
                    load_settings(8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'hFF);
                end
                1: load_settings(8'd255, 8'd255, 8'd254, 8'd100, 8'd200, 8'hA5);
                // shrinking the revolution leaves stale positions above it
                2: load_settings(8'd8, 8'd2, 8'd7, 8'd1, 8'd6, 8'h5A);
                3: load_settings(8'd1, 8'd1, 8'd0, 8'd0, 8'd2, 8'h0F);
                4: load_settings(8'd3, 8'd3, 8'd254, 8'd255, 8'd255, 8'hF0);
                5: load_settings(8'd96, 8'd8, 8'd40, 8'd10, 8'd80, 8'h00);
                6: load_settings(8'd200, 8'd0, 8'd128, 8'd255, 8'd0, 8'h3C);
                default: load_settings(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 1) ? $urandom_range(0, 12)
                                                               : $urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
            endcase
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                reel = 3'($urandom_range(0, srpt_pkg::NUM_REELS - 1));
                pick = $urandom_range(0, 99);
                // mostly real half-step drive, some repeats, some arbitrary nibbles
                if (pick < 15)
                    pat = last_sent[reel];
                else if (pick < 80)
                    pat = HALF_STEP_SEQ[4 * $urandom_range(0, 7) +: 4];
                else
                    pat = 4'($urandom_range(0, 15));
                send_drive(reel, pat);
                if ($urandom_range(0, 49) == 0)
                    drain_results;
            end
        end

        drain_results;
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Safety net well beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
